>>> hdl/swst_pkg.sv
// package: shared types and constants for the sliding window statistics core
`default_nettype none
package swst_pkg;

  localparam int MAX_WIN   = 16;
  localparam int SAMPLE_W  = 32;
  localparam int WLEN_W    = 5;
  localparam int SLEN_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SER_LEN = 1'd1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_WARN = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } in_t;

  typedef struct packed {
    logic signed [31:0] win_min;
    logic signed [31:0] win_mean;
    logic signed [31:0] win_max;
    logic signed [31:0] win_median;
    logic        [30:0] win_stddev;
    logic        [1:0]  status;
  } out_t;

endpackage
`default_nettype wire

>>> hdl/sliding_window_statistics_core.sv
// top level: sliding window min, mean, max, median and standard deviation
//
// Input beats carry one signed Q16.16 sample and a restart flag; each
// accepted beat yields exactly one result beat on the output channel.
// Both channels use valid/stall; the block raises in_stall from the cycle
// after an accepted beat until its result is loaded into the output
// register, so it works on one sample at a time. A finished result waits in
// the output register while the receiver stalls, and the next sample is
// already taken meanwhile.
// For a window of W samples, the window is gathered from the sample
// ring one entry a cycle; min/max/sum are kept while the sum of squares
// and sum^2 run through one shared 32x32 multiplier; then come a bit-serial
// divider (72 steps for the variance, 36 for the mean), a 32-step square
// root and W odd/even transposition phases for the median. The variance
// steps are skipped for the first sample of a series or W=1, and the
// square root for a saturated deviation; an error status result skips
// all computation and goes straight to the output stage.
// Configuration writes are taken at any time but belong to idle periods.
// Synchronous reset empties the output register, restarts the series and
// loads window_length=4 and series_length=16.
`default_nettype none
module sliding_window_statistics_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire swst_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output swst_pkg::out_t                   out_data,
  input  wire                              cfg_we,
  input  wire [swst_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [swst_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import swst_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_STAT = 4'd2;
  localparam logic [3:0] S_VAR  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_SORT = 4'd6;
  localparam logic [3:0] S_MED0 = 4'd7;
  localparam logic [3:0] S_MED1 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]  state;
  logic [6:0]  cnt;

  logic [WLEN_W-1:0] window_length;
  logic [SLEN_W-1:0] series_length;

  logic signed [31:0] store [MAX_WIN];
  logic signed [31:0] first_sample;
  logic [4:0]         samples_seen;
  logic [3:0]         write_slot;
  logic [3:0]         newest;
  logic               first_item;

  logic signed [31:0] win [MAX_WIN];
  logic signed [31:0] win_nx [MAX_WIN];
  logic signed [31:0] rd_q;
  logic               ld_v;
  logic               ld_first;
  logic [3:0]         ld_i;

  logic signed [31:0] mn;
  logic signed [31:0] mx;
  logic signed [35:0] sum;
  logic [66:0]        sxx;
  logic [71:0]        acc;
  logic               p1;
  logic               p2;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic [71:0] div_num;
  logic [7:0]  div_rem;
  logic [7:0]  div_d;
  logic [6:0]  div_n;
  logic        div_var;

  logic [62:0] sq_v;
  logic [62:0] sq_res;
  logic [62:0] sq_bit;

  logic signed [31:0] med_a;
  out_t               res;

  // combinational helpers
  logic               in_acc;
  logic               first_c;
  logic [3:0]         newest_c;
  logic [4:0]         seen_base;
  logic               err_c;
  logic [3:0]         rd_idx;
  logic signed [31:0] win_rd;
  logic [31:0]        v_mag;
  logic [35:0]        sum_mag;
  logic [71:0]        w_sxx;
  logic [8:0]         div_r;
  logic               div_ge;
  logic [7:0]         div_rem_nx;
  logic [71:0]        div_num_nx;
  logic [62:0]        sq_t;
  logic               sq_ge;
  logic [62:0]        sq_res_nx;
  logic [62:0]        sq_v_nx;
  logic [3:0]         idx_lo;
  logic [3:0]         idx_hi;
  logic [4:0]         w_m1;
  logic [7:0]         w_d;
  logic signed [32:0] med_s;
  logic signed [32:0] med_t;
  logic [35:0]        mean_q;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign first_c  = in_data.restart || (samples_seen == 5'd0);
  assign newest_c = first_c ? 4'd0 : write_slot;
  assign seen_base = first_c ? 5'd0 : samples_seen;
  assign err_c    = (series_length < SLEN_W'(2)) || (window_length == 5'd0) ||
                    (window_length > WLEN_W'(MAX_WIN));

  assign w_m1   = window_length - 5'd1;
  assign idx_lo = w_m1[4:1];
  assign idx_hi = window_length[4:1];
  assign w_d    = 8'(window_length) * 8'(w_m1);

  always_comb begin
    case (state)
      S_MED0:  rd_idx = idx_lo;
      S_MED1:  rd_idx = idx_hi;
      default: rd_idx = cnt[3:0];
    endcase
  end

  assign win_rd  = win[rd_idx];
  assign v_mag   = win_rd[31] ? (~win_rd + 32'd1) : win_rd;
  assign sum_mag = sum[35] ? (~sum + 36'd1) : sum;
  assign mean_q  = div_num_nx[35:0];

  // times window length by shift and add
  always_comb begin
    w_sxx = '0;
    for (int b = 0; b < WLEN_W; b++) begin
      if (window_length[b]) w_sxx = w_sxx + (72'(sxx) << b);
    end
  end

  // one restoring division step
  assign div_r      = {div_rem, div_num[71]};
  assign div_ge     = div_r >= {1'b0, div_d};
  assign div_rem_nx = div_ge ? 8'(div_r - {1'b0, div_d}) : div_r[7:0];
  assign div_num_nx = {div_num[70:0], div_ge};

  // one square root step
  assign sq_t      = sq_res + sq_bit;
  assign sq_ge     = sq_v >= sq_t;
  assign sq_res_nx = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  assign sq_v_nx   = sq_ge ? (sq_v - sq_t) : sq_v;

  // odd/even compare-exchange lanes
  always_comb begin
    for (int k = 0; k < MAX_WIN; k++) win_nx[k] = win[k];
    for (int k = 0; k < MAX_WIN - 1; k++) begin
      if ((k[0] == cnt[0]) && (5'(k + 1) < window_length) && (win[k] > win[k+1])) begin
        win_nx[k]   = win[k+1];
        win_nx[k+1] = win[k];
      end
    end
  end

  assign med_s = {med_a[31], med_a} + {win_rd[31], win_rd};
  assign med_t = med_s + {32'd0, med_s[32]};

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (in_acc) store[newest_c] <= in_data.sample;
    if (state == S_LOAD) rd_q <= store[4'(newest - cnt[3:0])];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      window_length <= WLEN_W'(4);
      series_length <= SLEN_W'(16);
      first_sample  <= '0;
      samples_seen  <= '0;
      write_slot    <= '0;
      ld_v          <= 1'b0;
      p1            <= 1'b0;
      p2            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WIN_LEN: window_length <= cfg_data[WLEN_W-1:0];
          REG_SER_LEN: series_length <= cfg_data[SLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (first_c) first_sample <= in_data.sample;
            newest       <= newest_c;
            write_slot   <= newest_c + 4'd1;
            samples_seen <= (seen_base < 5'(MAX_WIN)) ? seen_base + 5'd1 : seen_base;
            first_item   <= first_c;
            res          <= '0;
            cnt          <= '0;
            if (err_c) begin
              res.status <= ST_ERR;
              state      <= S_DONE;
            end else begin
              res.status <= ((window_length > 5'(series_length > 16'd31 ? 16'd31 :
                              series_length)) || (window_length == 5'd1)) ? ST_WARN : ST_OK;
              state      <= S_LOAD;
            end
          end
        end

        S_LOAD: begin
          ld_v     <= (cnt < 7'(window_length));
          ld_first <= (cnt >= {2'b0, samples_seen});
          ld_i     <= cnt[3:0];
          if (ld_v) win[ld_i] <= ld_first ? first_sample : rd_q;
          if (cnt == 7'(window_length)) begin
            ld_v  <= 1'b0;
            cnt   <= '0;
            state <= S_STAT;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        S_STAT: begin
          p1 <= 1'b0;
          p2 <= p1;
          if (p2) sxx <= sxx + 67'(mul_p);
          if (cnt < 7'(window_length)) begin
            mul_a <= v_mag;
            mul_b <= v_mag;
            p1    <= 1'b1;
            if (cnt == 7'd0) begin
              mn  <= win_rd;
              mx  <= win_rd;
              sum <= 36'(win_rd);
              sxx <= '0;
            end else begin
              if (win_rd < mn) mn <= win_rd;
              if (win_rd > mx) mx <= win_rd;
              sum <= sum + 36'(win_rd);
            end
          end
          if (cnt == 7'(window_length) + 7'd1) begin
            cnt <= '0;
            if (first_item || (window_length == 5'd1)) begin
              div_num <= {sum_mag, 36'd0};
              div_rem <= '0;
              div_d   <= {3'd0, window_length};
              div_n   <= 7'd36;
              div_var <= 1'b0;
              state   <= S_DIV;
            end else begin
              state <= S_VAR;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        // n*sum(x^2) - sum^2, with sum^2 built from 32-bit partial products
        S_VAR: begin
          cnt <= cnt + 7'd1;
          case (cnt[2:0])
            3'd0: begin
              acc   <= w_sxx;
              mul_a <= sum_mag[31:0];
              mul_b <= sum_mag[31:0];
            end
            3'd1: begin
              mul_a <= sum_mag[31:0];
              mul_b <= {28'd0, sum_mag[35:32]};
            end
            3'd2: begin
              acc   <= acc - 72'(mul_p);
              mul_a <= {28'd0, sum_mag[35:32]};
              mul_b <= {28'd0, sum_mag[35:32]};
            end
            3'd3: acc <= acc - {mul_p[38:0], 33'd0};
            3'd4: acc <= acc - {mul_p[7:0], 64'd0};
            default: begin
              div_num <= acc;
              div_rem <= '0;
              div_d   <= w_d;
              div_n   <= 7'd72;
              div_var <= 1'b1;
              cnt     <= '0;
              state   <= S_DIV;
            end
          endcase
        end

        S_DIV: begin
          div_num <= div_num_nx;
          div_rem <= div_rem_nx;
          if (cnt == div_n - 7'd1) begin
            cnt <= '0;
            if (div_var) begin
              if (|div_num_nx[71:62]) begin
                res.win_stddev <= 31'h7FFF_FFFF;
                div_num <= {sum_mag, 36'd0};
                div_rem <= '0;
                div_d   <= {3'd0, window_length};
                div_n   <= 7'd36;
                div_var <= 1'b0;
              end else begin
                sq_v   <= {1'b0, div_num_nx[61:0]};
                sq_res <= '0;
                sq_bit <= 63'd1 << 62;
                state  <= S_SQRT;
              end
            end else begin
              res.win_mean <= sum[35] ? 32'(~mean_q + 36'd1) : mean_q[31:0];
              state        <= S_SORT;
            end
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        S_SQRT: begin
          sq_v   <= sq_v_nx;
          sq_res <= sq_res_nx;
          sq_bit <= sq_bit >> 2;
          if (cnt == 7'd31) begin
            cnt            <= '0;
            res.win_stddev <= sq_res_nx[30:0];
            div_num        <= {sum_mag, 36'd0};
            div_rem        <= '0;
            div_d          <= {3'd0, window_length};
            div_n          <= 7'd36;
            div_var        <= 1'b0;
            state          <= S_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        S_SORT: begin
          for (int k = 0; k < MAX_WIN; k++) win[k] <= win_nx[k];
          if (cnt == 7'(w_m1)) begin
            cnt   <= '0;
            state <= S_MED0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end

        S_MED0: begin
          med_a <= win_rd;
          state <= S_MED1;
        end

        S_MED1: begin
          res.win_min    <= mn;
          res.win_max    <= mx;
          res.win_median <= med_t[32:1];
          state          <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/swst_checker.sv
// checker: port-level properties of the sliding window statistics core
`default_nettype none
module swst_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire swst_pkg::out_t   out_data
);
  import swst_pkg::*;

  // one sample at a time: an accepted beat closes the input
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ERR |->
      out_data.win_min == 0 && out_data.win_mean == 0 && out_data.win_max == 0 &&
      out_data.win_median == 0 && out_data.win_stddev == 0)
    else $error("error result with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind sliding_window_statistics_core swst_checker u_swst_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
